@@ design/bxf_pkg.sv @@
package bxf_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_CHANNEL_MODE = 2'd0;
	localparam logic [1:0] REG_COEFF_BANK   = 2'd1;
	localparam logic [1:0] REG_TAP_COUNT    = 2'd2;

	// channel modes
	localparam logic [1:0] MODE_STEREO = 2'd0;
	localparam logic [1:0] MODE_SURR51 = 2'd1;
	localparam logic [1:0] MODE_SURR71 = 2'd2;

	// word kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_COEFF  = 1'b1;

	// coefficient tables per bank, lane pairs
	localparam int TABLES_PER_BANK = 6;
	localparam int NUM_TABLES      = 12;
	localparam int NUM_LANES       = 3;

	// fixed field widths
	localparam int MODE_W  = 2;
	localparam int TCNT_W  = 8;
	localparam int CTAB_W  = 4;
	localparam int CIDX_W  = 7;
	localparam int CFGI_W  = 2;
	localparam int CFGD_W  = 8;
	localparam int LANE_W  = 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_WAIT,
		S_MERGE,
		S_OUT
	} bxf_state_t;

	// per-lane control flags
	typedef struct packed {
		logic clr;
		logic hist_we;
		logic coef_we_near;
		logic coef_we_far;
		logic rd_en;
		logic tap_ok;
		logic last;
	} bxf_ctl_t;

	// decoded coefficient target
	typedef struct packed {
		logic              ok;
		logic              bank;
		logic [LANE_W-1:0] lane;
		logic              far;
	} bxf_ctab_t;

	function automatic bxf_ctab_t decode_table(input logic [CTAB_W-1:0] t);
		bxf_ctab_t   d;
		logic [CTAB_W-1:0] tbl;
		d.ok   = (t < CTAB_W'(NUM_TABLES));
		d.bank = (t >= CTAB_W'(TABLES_PER_BANK));
		tbl    = d.bank ? (t - CTAB_W'(TABLES_PER_BANK)) : t;
		d.lane = tbl[LANE_W:1];
		d.far  = tbl[0];
		return d;
	endfunction

endpackage

@@ design/binaural_crossfeed_fir.sv @@
// channel | handshake           | payload
// in      | in_valid/in_stall   | kind, coeff_table, coeff_index, coeff_value, 8 samples
// out     | out_valid/out_stall | left_ear, right_ear
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
// a sample word is stepped one tap per cycle through the three pair lanes, then
// passes the read, multiply and accumulate registers, a merge state and an output
// load state before its result is in the output register; the next word is taken
// only after that. a coefficient word is written without entering the sequencer.
// no clearing pass: a fill count masks taps older than the last clear. reset and
// any register write empty the histories.
// input stalls while a word is in flight; a stalled output holds the core in its load
// state until the output register is free.
module binaural_crossfeed_fir #(
	parameter int MAX_TAPS    = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int COEFF_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [bxf_pkg::CTAB_W-1:0]          coeff_table,
	input  logic [bxf_pkg::CIDX_W-1:0]          coeff_index,
	input  logic signed [COEFF_BITS-1:0]        coeff_value,
	input  logic signed [SAMPLE_BITS-1:0]       front_left,
	input  logic signed [SAMPLE_BITS-1:0]       front_right,
	input  logic signed [SAMPLE_BITS-1:0]       center,
	input  logic signed [SAMPLE_BITS-1:0]       lfe,
	input  logic signed [SAMPLE_BITS-1:0]       rear_left,
	input  logic signed [SAMPLE_BITS-1:0]       rear_right,
	input  logic signed [SAMPLE_BITS-1:0]       side_left,
	input  logic signed [SAMPLE_BITS-1:0]       side_right,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       left_ear,
	output logic signed [SAMPLE_BITS-1:0]       right_ear,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bxf_pkg::CFGI_W-1:0]          cfg_index,
	input  logic [bxf_pkg::CFGD_W-1:0]          cfg_data
);

	import bxf_pkg::*;

	localparam int TAP_W = $clog2(MAX_TAPS);
	localparam int CNT_W = TAP_W + 1;
	localparam int ACC_W = SAMPLE_BITS + COEFF_BITS + TAP_W + 5;

	bxf_state_t state_q, state_d;

	logic [MODE_W-1:0] mode_q;
	logic              bank_q;
	logic [TCNT_W-1:0] tcnt_q;
	logic [TAP_W-1:0]  wp_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  tap_i_q;
	logic [TAP_W-1:0]  rd_p_q;
	logic signed [SAMPLE_BITS-1:0] cen_q, lfe_q;
	logic signed [ACC_W-1:0] sum_l_q, sum_r_q;

	logic in_acc, smp_acc, coef_acc, cfg_acc, cfg_clr, surr, side, last_tap;
	logic [CNT_W-1:0] taps;
	logic [TAP_W-1:0] pos;
	logic [31:0]      tc32;
	bxf_ctab_t        ctab;
	bxf_ctl_t         ctl [NUM_LANES];

	logic signed [SAMPLE_BITS-1:0] hl [NUM_LANES];
	logic signed [SAMPLE_BITS-1:0] hr [NUM_LANES];
	logic signed [ACC_W-1:0]       acc_l [NUM_LANES];
	logic signed [ACC_W-1:0]       acc_r [NUM_LANES];
	logic [NUM_LANES-1:0]          done;

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid & ~in_stall;
	assign smp_acc   = in_acc & (kind == KIND_SAMPLE);
	assign coef_acc  = in_acc & (kind == KIND_COEFF);
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign cfg_clr   = cfg_acc & ((cfg_index == REG_CHANNEL_MODE) |
		(cfg_index == REG_COEFF_BANK) | (cfg_index == REG_TAP_COUNT));

	// mode decode, mode three acts as 7.1
	assign surr = (mode_q != MODE_STEREO);
	assign side = (mode_q >= MODE_SURR71);

	// taps in use and current write position
	assign tc32 = 32'(tcnt_q);
	assign taps = (tc32 == 32'd0) ? CNT_W'(1) :
		(tc32 > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(tcnt_q);
	assign pos  = (CNT_W'(wp_q) >= taps) ? '0 : wp_q;
	assign last_tap = (tap_i_q == taps - CNT_W'(1));
	assign ctab = decode_table(coeff_table);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STEREO;
			bank_q <= 1'b0;
			tcnt_q <= TCNT_W'(128);
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_CHANNEL_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_COEFF_BANK:   bank_q <= cfg_data[0];
				REG_TAP_COUNT:    tcnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// write pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (cfg_clr) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (smp_acc) begin
			wp_q <= (pos == '0) ? TAP_W'(taps - CNT_W'(1)) : pos - TAP_W'(1);
			if (fill_q < taps) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// tap sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			tap_i_q <= '0;
			rd_p_q  <= pos;
			cen_q   <= center;
			lfe_q   <= lfe;
		end else if (state_q == S_RUN) begin
			tap_i_q <= tap_i_q + CNT_W'(1);
			rd_p_q  <= (CNT_W'(rd_p_q) + CNT_W'(1) >= taps) ? '0 : rd_p_q + TAP_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (smp_acc) state_d = S_RUN;
			S_RUN:   if (last_tap) state_d = S_WAIT;
			S_WAIT:  if (done[0]) state_d = S_MERGE;
			S_MERGE: state_d = S_OUT;
			S_OUT:   if (!out_valid || !out_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// lane sample routing
	assign hl[0] = front_left;
	assign hr[0] = front_right;
	assign hl[1] = rear_left;
	assign hr[1] = rear_right;
	assign hl[2] = side_left;
	assign hr[2] = side_right;

	// per-lane control
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			ctl[k].clr          = smp_acc;
			ctl[k].hist_we      = smp_acc & ((k == 0) | ((k == 1) & surr) | ((k == 2) & side));
			ctl[k].coef_we_near = coef_acc & ctab.ok & (ctab.lane == LANE_W'(k)) & ~ctab.far &
				(32'(coeff_index) < 32'(MAX_TAPS));
			ctl[k].coef_we_far  = coef_acc & ctab.ok & (ctab.lane == LANE_W'(k)) & ctab.far &
				(32'(coeff_index) < 32'(MAX_TAPS));
			ctl[k].rd_en        = (state_q == S_RUN);
			ctl[k].tap_ok       = (tap_i_q < fill_q);
			ctl[k].last         = last_tap;
		end
	end

	// pair lanes
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		bxf_lane #(
			.MAX_TAPS(MAX_TAPS), .SAMPLE_BITS(SAMPLE_BITS),
			.COEFF_BITS(COEFF_BITS), .ACC_W(ACC_W)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl[g]),
			.hist_waddr(pos),
			.hist_l(hl[g]),
			.hist_r(hr[g]),
			.coef_waddr({ctab.bank, TAP_W'(coeff_index)}),
			.coef_wdata(coeff_value),
			.hist_raddr(rd_p_q),
			.coef_raddr({bank_q, TAP_W'(tap_i_q)}),
			.acc_l(acc_l[g]),
			.acc_r(acc_r[g]),
			.done(done[g])
		);
	end

	// merge lanes and the center/lfe term
	logic signed [ACC_W-1:0] mix;
	assign mix = surr ? ((ACC_W'(cen_q) + ACC_W'(lfe_q)) <<< (COEFF_BITS - 2)) : '0;

	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && done[0]) begin
			sum_l_q <= acc_l[0] + (surr ? acc_l[1] : '0) + (side ? acc_l[2] : '0) + mix;
			sum_r_q <= acc_r[0] + (surr ? acc_r[1] : '0) + (side ? acc_r[2] : '0) + mix;
		end
	end

	// round half up, saturate
	function automatic logic signed [SAMPLE_BITS-1:0] finish(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] u;
		logic signed [ACC_W-1:0] s;
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		u  = a + (ACC_W'(1) <<< (COEFF_BITS - 2));
		s  = u >>> (COEFF_BITS - 1);
		hi = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
		lo = -hi - ACC_W'(1);
		if (s > hi) begin
			return SAMPLE_BITS'(hi);
		end else if (s < lo) begin
			return SAMPLE_BITS'(lo);
		end
		return SAMPLE_BITS'(s);
	endfunction

	logic load_out;
	assign load_out = (state_q == S_MERGE) ? 1'b0 :
		((state_q == S_OUT) & (!out_valid || !out_stall));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_ear  <= finish(sum_l_q);
			right_ear <= finish(sum_r_q);
		end
	end

endmodule

@@ design/bxf_ram.sv @@
module bxf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/bxf_lane.sv @@
module bxf_lane #(
	parameter int MAX_TAPS    = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int COEFF_BITS  = 16,
	parameter int ACC_W       = 44
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bxf_pkg::bxf_ctl_t                 ctl,
	input  logic [$clog2(MAX_TAPS)-1:0]       hist_waddr,
	input  logic signed [SAMPLE_BITS-1:0]     hist_l,
	input  logic signed [SAMPLE_BITS-1:0]     hist_r,
	input  logic [$clog2(MAX_TAPS):0]         coef_waddr,
	input  logic signed [COEFF_BITS-1:0]      coef_wdata,
	input  logic [$clog2(MAX_TAPS)-1:0]       hist_raddr,
	input  logic [$clog2(MAX_TAPS):0]         coef_raddr,
	output logic signed [ACC_W-1:0]           acc_l,
	output logic signed [ACC_W-1:0]           acc_r,
	output logic                              done
);

	import bxf_pkg::*;

	localparam int PW = SAMPLE_BITS + COEFF_BITS;

	logic signed [SAMPLE_BITS-1:0] l_rd, r_rd;
	logic signed [COEFF_BITS-1:0]  cn_rd, cf_rd;

	// sample histories
	bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_l (
		.clk(clk), .we(ctl.hist_we), .waddr(hist_waddr), .wdata(hist_l),
		.raddr(hist_raddr), .rdata(l_rd)
	);
	bxf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_r (
		.clk(clk), .we(ctl.hist_we), .waddr(hist_waddr), .wdata(hist_r),
		.raddr(hist_raddr), .rdata(r_rd)
	);

	// near and far taps, both banks
	bxf_ram #(.WIDTH(COEFF_BITS), .DEPTH(2 * MAX_TAPS)) u_coef_n (
		.clk(clk), .we(ctl.coef_we_near), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(coef_raddr), .rdata(cn_rd)
	);
	bxf_ram #(.WIDTH(COEFF_BITS), .DEPTH(2 * MAX_TAPS)) u_coef_f (
		.clk(clk), .we(ctl.coef_we_far), .waddr(coef_waddr), .wdata(coef_wdata),
		.raddr(coef_raddr), .rdata(cf_rd)
	);

	logic en_s1, ok_s1, last_s1;
	logic en_s2, last_s2;
	logic signed [PW-1:0] ln_s2, rf_s2, rn_s2, lf_s2;

	// flags line up with read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1   <= 1'b0;
			ok_s1   <= 1'b0;
			last_s1 <= 1'b0;
			en_s2   <= 1'b0;
			last_s2 <= 1'b0;
			done    <= 1'b0;
		end else begin
			en_s1   <= ctl.rd_en;
			ok_s1   <= ctl.tap_ok;
			last_s1 <= ctl.rd_en & ctl.last;
			en_s2   <= en_s1;
			last_s2 <= last_s1;
			done    <= last_s2;
		end
	end

	// products, zero for taps older than the fill
	always_ff @(posedge clk) begin
		if (ok_s1) begin
			ln_s2 <= PW'(l_rd * cn_rd);
			rf_s2 <= PW'(r_rd * cf_rd);
			rn_s2 <= PW'(r_rd * cn_rd);
			lf_s2 <= PW'(l_rd * cf_rd);
		end else begin
			ln_s2 <= '0;
			rf_s2 <= '0;
			rn_s2 <= '0;
			lf_s2 <= '0;
		end
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_l <= '0;
			acc_r <= '0;
		end else if (en_s2) begin
			acc_l <= acc_l + ACC_W'(ln_s2) + ACC_W'(rf_s2);
			acc_r <= acc_r + ACC_W'(rn_s2) + ACC_W'(lf_s2);
		end
	end

endmodule
